### rtl/mnpr_pkg.sv
// mnpr_pkg: types and constants for the midi note pair recorder
// beat structs, pending table entry layout and midi status codes
// no dependencies
package mnpr_pkg;

	localparam int TICK_WIDTH  = 32;
	localparam int PITCH_WIDTH = 7;
	localparam int VEL_WIDTH   = 7;
	localparam int CHAN_WIDTH  = 4;
	localparam int KEY_WIDTH   = CHAN_WIDTH + PITCH_WIDTH;
	localparam int TABLE_DEPTH = 1 << KEY_WIDTH;

	localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
	localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
	localparam logic       ACTION_CLEAR    = 1'b1;
	localparam logic [1:0] FULL_MSG_COUNT  = 2'd3;

	localparam logic [TICK_WIDTH-1:0] MIN_LENGTH = TICK_WIDTH'(10);

	typedef logic [KEY_WIDTH-1:0] key_t;

	typedef struct packed {
		logic                  action;
		logic [1:0]            byte_count;
		logic [7:0]            status_byte;
		logic [7:0]            data_one;
		logic [7:0]            data_two;
		logic [TICK_WIDTH-1:0] msg_tick;
	} cmd_t;

	typedef struct packed {
		logic [PITCH_WIDTH-1:0] note_pitch;
		logic [VEL_WIDTH-1:0]   note_velocity;
		logic [TICK_WIDTH-1:0]  note_start;
		logic [TICK_WIDTH-1:0]  note_length;
	} note_t;

	typedef struct packed {
		logic                  valid;
		logic [VEL_WIDTH-1:0]  velocity;
		logic [TICK_WIDTH-1:0] start;
	} entry_t;

	// table index: channel then pitch
	function automatic key_t key_of(input logic [7:0] status_byte, input logic [7:0] data_one);
		return {status_byte[CHAN_WIDTH-1:0], data_one[PITCH_WIDTH-1:0]};
	endfunction

endpackage

### rtl/midi_note_pair_recorder_top.sv
// midi_note_pair_recorder_top: pairs note-on and note-off messages into notes
// pending table in one synchronous memory, read-modify-write with forwarding
// depends on mnpr_pkg
//
// channel   signals                      direction  handshake
// command   start, busy, item            in         taken when start & !busy
// result    done, note                   out        one-cycle strobe, no stall
// config    cfg_we, cfg_wdata            in         written when cfg_we
//
// one command is taken per cycle while not busy; a note-off goes through stage 1
// and the result register. the table read is issued at acceptance, the write-back
// in the cycle after, and a back-to-back access to the same entry is forwarded
// from the write-back. a clear command, and reset, start a sweep over all 2048
// table entries, one per cycle; busy stays high for the whole sweep.
// the result side has no back-pressure; each note is shown for one cycle.
module midi_note_pair_recorder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  mnpr_pkg::cmd_t     item,
	output logic               done,
	output mnpr_pkg::note_t    note,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);
	import mnpr_pkg::*;

	logic   accept;
	logic   rec_q;
	logic   sweep_q;
	key_t   sweep_addr_q;
	logic   v_s1;
	cmd_t   item_s1;
	key_t   key_s1;
	entry_t rdata_s1;
	logic   fwd_s1;
	entry_t fwd_entry_s1;
	entry_t mem [TABLE_DEPTH];

	key_t   in_key;
	entry_t cur_entry;
	logic   msg_ok;
	logic   is_on;
	logic   is_off;
	logic   press;
	logic   hit;
	logic   s1_wr;
	entry_t s1_wdata;
	logic   mem_we;
	key_t   mem_waddr;
	entry_t mem_wdata;
	logic [TICK_WIDTH:0]   diff;
	logic [TICK_WIDTH-1:0] length;

	assign accept = start & ~busy;
	assign busy   = sweep_q;
	assign in_key = key_of(item.status_byte, item.data_one);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= 1'b0;
		end else if (cfg_we) begin
			rec_q <= cfg_wdata;
		end
	end

	// table clearing sweep, after reset and on a clear command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_q) begin
			sweep_addr_q <= sweep_addr_q + key_t'(1);
			if (&sweep_addr_q) begin
				sweep_q <= 1'b0;
			end
		end else if (accept && item.action == ACTION_CLEAR) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end
	end

	// pending table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[in_key];
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= accept;
			fwd_s1 <= s1_wr && (key_s1 == in_key);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		item_s1      <= item;
		key_s1       <= in_key;
		fwd_entry_s1 <= s1_wdata;
	end

	// decode and entry update
	always_comb begin
		cur_entry = fwd_s1 ? fwd_entry_s1 : rdata_s1;
		is_on     = item_s1.status_byte[7:4] == STATUS_NOTE_ON;
		is_off    = item_s1.status_byte[7:4] == STATUS_NOTE_OFF;
		msg_ok    = v_s1 && item_s1.action != ACTION_CLEAR
		            && item_s1.byte_count == FULL_MSG_COUNT && rec_q && (is_on || is_off);
		press     = msg_ok && is_on && item_s1.data_two[VEL_WIDTH-1:0] != '0;
		hit       = msg_ok && !press && cur_entry.valid;
		s1_wr     = press || hit;
		if (press) begin
			s1_wdata.valid    = 1'b1;
			s1_wdata.velocity = item_s1.data_two[VEL_WIDTH-1:0];
			s1_wdata.start    = item_s1.msg_tick;
		end else begin
			s1_wdata       = cur_entry;
			s1_wdata.valid = 1'b0;
		end
	end

	// write port: sweep or write-back
	always_comb begin
		mem_we    = sweep_q || s1_wr;
		mem_waddr = sweep_q ? sweep_addr_q : key_s1;
		mem_wdata = s1_wdata;
		if (sweep_q) begin
			mem_wdata = '0;
		end
	end

	// note length with floor
	always_comb begin
		diff = {1'b0, item_s1.msg_tick} - {1'b0, cur_entry.start};
		if (diff[TICK_WIDTH] || diff[TICK_WIDTH-1:0] < MIN_LENGTH) begin
			length = MIN_LENGTH;
		end else begin
			length = diff[TICK_WIDTH-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= hit;
		end
	end

	always_ff @(posedge clk) begin
		note.note_pitch    <= item_s1.data_one[PITCH_WIDTH-1:0];
		note.note_velocity <= cur_entry.velocity;
		note.note_start    <= cur_entry.start;
		note.note_length   <= length;
	end

	// checks
	a_done_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s1))
		else $error("result without a command in stage 1");

	a_no_wr_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !s1_wr)
		else $error("write-back collides with clearing sweep");

	a_sweep_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sweep_q) |-> sweep_addr_q == '0)
		else $error("sweep ended before covering the table");

	a_min_length: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> note.note_length >= MIN_LENGTH)
		else $error("note length below floor");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q && $past(sweep_q) |-> !v_s1)
		else $error("command taken during sweep");

endmodule
